/* hw/rtl/utf8_bmp_decoder_top_defines.svh */
// Assertion macros used by the decoder's checker file.
`ifndef UTF8_BMP_DECODER_TOP_DEFINES_SVH
`define UTF8_BMP_DECODER_TOP_DEFINES_SVH

// Clocked property, off while reset is held.
`define U8BMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked property, also checked while reset is held.
`define U8BMP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/u8bmp_pkg.sv */
// Types, codes and constants of the UTF-8 BMP decoder.
package u8bmp_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_BAD_CONT = 3'd2,
        ST_TOO_WIDE = 3'd3,
        ST_TRUNC    = 3'd4
    } t_status;

    localparam logic [7:0] LEAD_TWO_MIN   = 8'hC2;
    localparam logic [7:0] LEAD_THREE_MIN = 8'hE0;
    localparam logic [7:0] LEAD_WIDE_MIN  = 8'hF0;
    localparam logic [7:0] ASCII_LIMIT    = 8'h80;
    localparam logic [7:0] E0_CONT_MIN    = 8'hA0;
    localparam logic [1:0] CONT_TAG       = 2'b10;

    typedef struct packed {
        logic [1:0]  bytes_left;
        logic [15:0] partial_value;
        logic        first_cont_check;
        logic        discarding;
    } t_dec_state;

    typedef struct packed {
        logic        valid;
        logic [15:0] codepoint;
        t_status     status;
        logic        last_of_string;
    } t_dec_result;

endpackage

/* hw/rtl/u8bmp_step.sv */
// Per-byte decode: next sequence state and optional result for one request.
module u8bmp_step (
    input  u8bmp_pkg::t_dec_state  i_state,
    input  logic [7:0]             i_byte_in,
    input  logic                   i_string_end,
    output u8bmp_pkg::t_dec_state  o_state,
    output u8bmp_pkg::t_dec_result o_result
);
    import u8bmp_pkg::*;

    logic    fail;
    t_status fail_status;

    always_comb begin
        o_state                 = i_state;
        o_result.valid          = 1'b0;
        o_result.codepoint      = '0;
        o_result.status         = ST_OK;
        o_result.last_of_string = i_string_end;
        fail                    = 1'b0;
        fail_status             = ST_OK;

        if (i_state.discarding) begin
            if (i_string_end) begin
                o_state = '0;
            end
        end else if (i_state.bytes_left == 2'd0) begin
            if (i_byte_in < ASCII_LIMIT) begin
                o_result.valid     = 1'b1;
                o_result.codepoint = {8'h00, i_byte_in};
            end else if (i_byte_in < LEAD_TWO_MIN) begin
                fail        = 1'b1;
                fail_status = ST_BAD_LEAD;
            end else if (i_byte_in < LEAD_THREE_MIN) begin
                o_state.partial_value    = {5'd0, i_byte_in[4:0], 6'd0};
                o_state.bytes_left       = 2'd1;
                o_state.first_cont_check = 1'b0;
                fail                     = i_string_end;
                fail_status              = ST_TRUNC;
            end else if (i_byte_in < LEAD_WIDE_MIN) begin
                o_state.partial_value    = {i_byte_in[3:0], 12'd0};
                o_state.bytes_left       = 2'd2;
                o_state.first_cont_check = (i_byte_in == LEAD_THREE_MIN);
                fail                     = i_string_end;
                fail_status              = ST_TRUNC;
            end else begin
                fail        = 1'b1;
                fail_status = ST_TOO_WIDE;
            end
        end else if ((i_byte_in[7:6] != CONT_TAG)
                     || (i_state.first_cont_check && (i_byte_in < E0_CONT_MIN))) begin
            fail        = 1'b1;
            fail_status = ST_BAD_CONT;
        end else if (i_state.bytes_left == 2'd2) begin
            o_state.first_cont_check = 1'b0;
            o_state.partial_value    = i_state.partial_value | {4'd0, i_byte_in[5:0], 6'd0};
            o_state.bytes_left       = 2'd1;
            fail                     = i_string_end;
            fail_status              = ST_TRUNC;
        end else begin
            o_state                  = '0;
            o_result.valid           = 1'b1;
            o_result.codepoint       = i_state.partial_value | {10'd0, i_byte_in[5:0]};
        end

        if (fail) begin
            o_state                 = '0;
            o_state.discarding      = !i_string_end;
            o_result.valid          = 1'b1;
            o_result.codepoint      = '0;
            o_result.status         = fail_status;
        end
    end

endmodule

/* hw/rtl/utf8_bmp_decoder_top.sv */
// Top level of the UTF-8 to 16-bit codepoint decoder.
// A result is registered and appears at the output in the cycle after its byte's request.
// Throughput: one byte per cycle while the output is not stalled; the output register frees itself when taken.
// A byte is taken whenever the result register is empty or is drained that cycle.
// Reset clears the sequence state, the drop flag and the output valid.
module utf8_bmp_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_string_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_codepoint,
    output logic [2:0]  o_status,
    output logic        o_last_of_string
);
    import u8bmp_pkg::*;

    t_dec_state  r_state;
    t_dec_state  n_state;
    t_dec_result n_result;
    logic        r_out_valid;
    logic [15:0] r_codepoint;
    t_status     r_status;
    logic        r_last;
    logic        in_fire;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    u8bmp_step u_step (
        .i_state      (r_state),
        .i_byte_in    (i_byte_in),
        .i_string_end (i_string_end),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire && n_result.valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_result.valid) begin
            r_codepoint <= n_result.codepoint;
            r_status    <= n_result.status;
            r_last      <= n_result.last_of_string;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_codepoint      = r_codepoint;
    assign o_status         = r_status;
    assign o_last_of_string = r_last;

endmodule

/* hw/rtl/u8bmp_checker.sv */
// Port-level checker for the decoder top level, with its bind.
`include "utf8_bmp_decoder_top_defines.svh"

module u8bmp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_codepoint,
    input logic [2:0]  o_status,
    input logic        o_last_of_string
);
    import u8bmp_pkg::*;

    `U8BMP_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `U8BMP_ASSERT(a_ready_when_empty, !o_out_valid |-> o_in_ready, "not ready while output empty")
    `U8BMP_ASSERT(a_stall_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_codepoint) && $stable(o_status) && $stable(o_last_of_string), "stalled result changed")
    `U8BMP_ASSERT(a_error_zero, o_out_valid && (o_status != ST_OK) |-> (o_codepoint == 16'd0), "error result carries a codepoint")
    `U8BMP_ASSERT(a_trunc_last, o_out_valid && (o_status == ST_TRUNC) |-> o_last_of_string, "truncation away from string end")

endmodule

bind utf8_bmp_decoder_top u8bmp_checker u_u8bmp_checker (.*);

/* bench/tb_top.sv */
// Self-checking testbench for the UTF-8 to 16-bit codepoint decoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import u8bmp_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_BYTES = 1350;
    localparam int MAX_GAP      = 12;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 400000;

    class decode_scoreboard;
        typedef struct {
            logic [15:0] codepoint;
            t_status     status;
            logic        last_of_string;
        } t_decoded;

        t_decoded    decoded_q[$];
        logic [1:0]  bytes_left;
        logic [15:0] partial_value;
        bit          first_cont_check;
        bit          dropping;
        int          byte_count;
        int          errors;

        function new();
            bytes_left       = '0;
            partial_value    = '0;
            first_cont_check = 1'b0;
            dropping         = 1'b0;
            byte_count       = 0;
            errors           = 0;
        endfunction

        function void clear_sequence();
            bytes_left       = '0;
            partial_value    = '0;
            first_cont_check = 1'b0;
        endfunction

        function void push(logic [15:0] cp, t_status st, logic last);
            t_decoded d;
            d.codepoint      = cp;
            d.status         = st;
            d.last_of_string = last;
            decoded_q = {decoded_q, d};
        endfunction

        function void abort_string(t_status st, logic last);
            clear_sequence();
            dropping = !last;
            push(16'h0000, st, last);
        endfunction

        function void note_request(logic [7:0] b, logic last);
            logic [15:0] cp;
            byte_count++;
            if (dropping) begin
                if (last) begin
                    dropping = 1'b0;
                    clear_sequence();
                end
                return;
            end
            if (bytes_left == 2'd0) begin
                if (b < ASCII_LIMIT) begin
                    push({8'h00, b}, ST_OK, last);
                end else if (b < LEAD_TWO_MIN) begin
                    abort_string(ST_BAD_LEAD, last);
                end else if (b < LEAD_WIDE_MIN) begin
                    if (b < LEAD_THREE_MIN) begin
                        partial_value    = {5'b0, b[4:0], 6'b0};
                        bytes_left       = 2'd1;
                        first_cont_check = 1'b0;
                    end else begin
                        partial_value    = {b[3:0], 12'b0};
                        bytes_left       = 2'd2;
                        first_cont_check = (b == LEAD_THREE_MIN);
                    end
                    if (last)
                        abort_string(ST_TRUNC, last);
                end else begin
                    abort_string(ST_TOO_WIDE, last);
                end
                return;
            end
            if (b[7:6] != CONT_TAG || (first_cont_check && b < E0_CONT_MIN)) begin
                abort_string(ST_BAD_CONT, last);
                return;
            end
            first_cont_check = 1'b0;
            if (bytes_left == 2'd2) begin
                partial_value = partial_value | {4'b0, b[5:0], 6'b0};
                bytes_left    = 2'd1;
                if (last)
                    abort_string(ST_TRUNC, last);
                return;
            end
            cp = partial_value | {10'b0, b[5:0]};
            clear_sequence();
            push(cp, ST_OK, last);
        endfunction

        function void check_result(logic [15:0] cp, logic [2:0] st, logic last);
            t_decoded d;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result codepoint %h status %0d last %0b",
                         $time, cp, st, last);
                errors++;
                return;
            end
            d = decoded_q.pop_front();
            if (cp !== d.codepoint) begin
                $display("%0t: codepoint expected %h actual %h", $time, d.codepoint, cp);
                errors++;
            end
            if (st !== d.status) begin
                $display("%0t: status expected %0d actual %0d", $time, d.status, st);
                errors++;
            end
            if (last !== d.last_of_string) begin
                $display("%0t: last_of_string expected %0b actual %0b",
                         $time, d.last_of_string, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_byte_in        = 8'h00;
    logic        i_string_end     = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready      = 1'b0;
    logic [15:0] o_codepoint;
    logic [2:0]  o_status;
    logic        o_last_of_string;

    decode_scoreboard sb = new();
    bit               steady = 1'b0;
    int               cycles = 0;

    utf8_bmp_decoder_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_byte_in        (i_byte_in),
        .i_string_end     (i_string_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_codepoint      (o_codepoint),
        .o_status         (o_status),
        .o_last_of_string (o_last_of_string)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("utf8_bmp_decoder_top test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_request(i_byte_in, i_string_end);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_codepoint, o_status, o_last_of_string);
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_byte_in    <= b;
        i_string_end <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_string();
        logic [7:0] seq[$];
        logic [7:0] lead;
        int         n_chars;
        int         r;
        n_chars = $urandom_range(1, 6);
        steady  = ($urandom_range(0, 99) < 15);
        for (int k = 0; k < n_chars; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                seq = {seq, 8'($urandom_range(0, 127))};
            end else if (r < 50) begin
                seq = {seq, 8'($urandom_range(8'hC2, 8'hDF))};
                seq = {seq, cont_byte()};
            end else if (r < 75) begin
                lead = 8'($urandom_range(8'hE0, 8'hEF));
                seq = {seq, lead};
                seq = {seq, (lead == LEAD_THREE_MIN ?
                             8'($urandom_range(8'hA0, 8'hBF)) : cont_byte())};
                seq = {seq, cont_byte()};
            end else if (r < 85) begin
                seq = {seq, 8'($urandom_range(0, 255))};
            end else if (r < 92) begin
                seq = {seq, 8'($urandom_range(8'hC2, 8'hEF))};
                seq = {seq, 8'($urandom_range(0, 255))};
            end else begin
                seq = {seq, LEAD_THREE_MIN};
                seq = {seq, 8'($urandom_range(8'h80, 8'h9F))};
                seq = {seq, cont_byte()};
            end
        end
        if ($urandom_range(0, 9) == 0)
            seq = {seq, 8'($urandom_range(8'hC2, 8'hEF))};
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1);
    endtask

    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            int stall;
            stall = draw_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        int start_bytes;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hC1, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h9F, 1'b1);
        send_byte(8'hF0, 1'b1);
        send_byte(8'hC3, 1'b1);
        send_byte(8'hE1, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b1);

        start_bytes = sb.byte_count;
        while (sb.byte_count - start_bytes < RANDOM_BYTES)
            send_string();
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.decoded_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.decoded_q.size());
            sb.errors++;
        end

        if (sb.errors == 0) begin
            $display("utf8_bmp_decoder_top test passed");
        end else begin
            $display("utf8_bmp_decoder_top test failed");
        end
        $finish;
    end

endmodule
